### rtl/dht_pkg.sv
package dht_pkg;

  localparam int FrameBits  = 40;
  localparam int FrameW     = 40;
  localparam int BitCountW  = 6;
  localparam int TimeW      = 16;
  localparam int ByteW      = 8;
  localparam int CfgIndexW  = 3;

  localparam logic [ByteW-1:0] AckPhaseReset   = 8'd80;
  localparam logic [ByteW-1:0] InvalidAckReset = 8'd90;
  localparam logic [ByteW-1:0] BitGapReset     = 8'd20;
  localparam logic [ByteW-1:0] ZeroHighReset   = 8'd23;
  localparam logic [ByteW-1:0] OneHighReset    = 8'd75;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ACK_PHASE   = 3'd0,
    REG_INVALID_ACK = 3'd1,
    REG_BIT_GAP     = 3'd2,
    REG_ZERO_HIGH   = 3'd3,
    REG_ONE_HIGH    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic line_level;
    logic frame_done;
  } result_t;

endpackage

### rtl/dht_if.sv
interface dht_sample_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [dht_pkg::TimeW-1:0]    elapsed_us;
  logic [dht_pkg::ByteW-1:0]    humidity;
  logic [dht_pkg::ByteW-1:0]    temperature;
  logic                         reading_valid;

  modport source (output valid, cmd, elapsed_us, humidity, temperature, reading_valid,
                  input ready);
  modport sink (input valid, cmd, elapsed_us, humidity, temperature, reading_valid,
                output ready);
endinterface

interface dht_result_if;
  logic valid;
  logic ready;
  logic line_level;
  logic frame_done;

  modport source (output valid, line_level, frame_done, input ready);
  modport sink (input valid, line_level, frame_done, output ready);
endinterface

interface dht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dht_pkg::CfgIndexW-1:0] index;
  logic [dht_pkg::ByteW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/dht11_sensor_responder_unit.sv
// Channel   Dir  Payload
// sample    in   cmd, elapsed_us, humidity, temperature, reading_valid
// result    out  line_level, frame_done
// cfg       in   index, data (8-bit timing registers 0..4)
//
// One sample beat per cycle while sample.ready is high; its result is registered into the output stage on acceptance.
// The phase update for a beat is resolved in the accept cycle, so the next beat
// follows immediately. A two-entry output stage (result plus skid) keeps
// sample.ready high while one result waits; it drops only when both are full.
// Synchronous reset restores the register defaults, the started phase and an
// empty output stage. cfg is always ready.
module dht11_sensor_responder_unit (
  input  logic                clk,
  input  logic                rst,
  dht_sample_if.sink          sample,
  dht_result_if.source        result,
  dht_cfg_if.sink             cfg
);

  typedef enum logic [2:0] {
    PH_STARTED  = 3'd0,
    PH_ACK_LOW  = 3'd1,
    PH_ACK_HIGH = 3'd2,
    PH_BIT_GAP  = 3'd3,
    PH_BIT_HIGH = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  logic [dht_pkg::ByteW-1:0] ack_phase_us;
  logic [dht_pkg::ByteW-1:0] invalid_ack_us;
  logic [dht_pkg::ByteW-1:0] bit_gap_us;
  logic [dht_pkg::ByteW-1:0] zero_high_us;
  logic [dht_pkg::ByteW-1:0] one_high_us;

  phase_t                        phase, phase_next;
  logic [dht_pkg::BitCountW-1:0] bit_count, bit_count_next;
  logic [dht_pkg::FrameW-1:0]    frame_bits, frame_bits_next;

  dht_pkg::result_t res_new;
  dht_pkg::result_t out_data, skid_data;
  logic             out_valid, skid_valid;

  logic                          in_fire, out_free;
  logic [dht_pkg::TimeW-1:0]     t;
  logic [dht_pkg::ByteW-1:0]     sum;
  logic [dht_pkg::BitCountW-1:0] idx;
  logic                          cur_bit;
  logic [dht_pkg::ByteW-1:0]     limit;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !skid_valid;
  assign in_fire      = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;

  assign result.valid      = out_valid;
  assign result.line_level = out_data.line_level;
  assign result.frame_done = out_data.frame_done;

  assign t   = sample.elapsed_us;
  assign sum = sample.humidity + sample.temperature;
  assign idx = (bit_count < dht_pkg::BitCountW'(dht_pkg::FrameW))
               ? bit_count : dht_pkg::BitCountW'(dht_pkg::FrameW - 1);
  assign cur_bit = frame_bits[dht_pkg::BitCountW'(dht_pkg::FrameW - 1) - idx];
  assign limit   = cur_bit ? one_high_us : zero_high_us;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    frame_bits_next     = frame_bits;
    res_new.line_level  = 1'b0;
    if (!sample.cmd) begin
      phase_next     = PH_STARTED;
      bit_count_next = '0;
    end else begin
      unique case (phase)
        PH_STARTED: begin
          phase_next = PH_ACK_LOW;
        end
        PH_ACK_LOW: begin
          if (t >= {8'd0, ack_phase_us}) begin
            res_new.line_level = 1'b1;
            phase_next         = PH_ACK_HIGH;
          end
        end
        PH_ACK_HIGH: begin
          frame_bits_next = {sample.humidity, 8'd0, sample.temperature, 8'd0, sum};
          if (t < {8'd0, ack_phase_us} ||
              (!sample.reading_valid && t < {8'd0, invalid_ack_us})) begin
            res_new.line_level = 1'b1;
          end else begin
            phase_next = PH_BIT_GAP;
          end
        end
        PH_BIT_GAP: begin
          if (t >= {8'd0, bit_gap_us}) begin
            res_new.line_level = 1'b1;
            phase_next         = PH_BIT_HIGH;
          end
        end
        PH_BIT_HIGH: begin
          if (t < {8'd0, limit}) begin
            res_new.line_level = 1'b1;
          end else begin
            bit_count_next = bit_count + 1'b1;
            phase_next = (bit_count_next >= dht_pkg::BitCountW'(dht_pkg::FrameBits))
                         ? PH_DONE : PH_BIT_GAP;
          end
        end
        PH_DONE: begin
          res_new.line_level = 1'b0;
        end
        default: begin
          res_new.line_level = 1'b0;
        end
      endcase
    end
    res_new.frame_done = sample.cmd && (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_phase_us   <= dht_pkg::AckPhaseReset;
      invalid_ack_us <= dht_pkg::InvalidAckReset;
      bit_gap_us     <= dht_pkg::BitGapReset;
      zero_high_us   <= dht_pkg::ZeroHighReset;
      one_high_us    <= dht_pkg::OneHighReset;
      phase          <= PH_STARTED;
      bit_count      <= '0;
      frame_bits     <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          dht_pkg::REG_ACK_PHASE:   ack_phase_us   <= cfg.data;
          dht_pkg::REG_INVALID_ACK: invalid_ack_us <= cfg.data;
          dht_pkg::REG_BIT_GAP:     bit_gap_us     <= cfg.data;
          dht_pkg::REG_ZERO_HIGH:   zero_high_us   <= cfg.data;
          dht_pkg::REG_ONE_HIGH:    one_high_us    <= cfg.data;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        frame_bits <= frame_bits_next;
      end
      if (out_free) begin
        out_valid  <= skid_valid || in_fire;
        out_data   <= skid_valid ? skid_data : res_new;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
        skid_data  <= res_new;
      end
    end
  end

endmodule
